// File: hdl/amf3_pkg.sv
// shared types and constants for the amf3 number encoder
`timescale 1ns / 1ps
`default_nettype none
package amf3_pkg;
  localparam logic [7:0] INT_MARKER = 8'h04;
  localparam logic [7:0] DBL_MARKER = 8'h05;
  localparam int QueueDepth = 2;
  localparam int MaxBytes = 9;

  // classified item: byte sequence up to nine bytes, msb byte first
  typedef struct packed {
    logic [71:0] bytes;
    logic [3:0]  count;
  } amf3_item_t;
endpackage
`default_nettype wire

// File: hdl/amf3_front.sv
// front end: classifies a double and builds its byte sequence
`timescale 1ns / 1ps
`default_nettype none
module amf3_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [63:0]          double_bits,
  output amf3_pkg::amf3_item_t      item,
  output logic                      item_valid
);
  import amf3_pkg::*;

  logic        sgn;
  logic [10:0] ex;
  logic [51:0] man;
  logic [10:0] u;
  logic [52:0] frac_mask;
  logic [52:0] mag;
  logic [28:0] v;
  logic        is_int;
  amf3_item_t  built;

  always_comb begin
    sgn = double_bits[63];
    ex = double_bits[62:52];
    man = double_bits[51:0];
    u = ex - 11'd1023;
    is_int = 1'b0;
    v = '0;
    frac_mask = '0;
    mag = '0;
    if (ex == 11'd0) begin
      is_int = (man == 52'd0);
    end else if (ex != 11'h7ff && ex >= 11'd1023 && u <= 11'd28) begin
      if (u == 11'd28) begin
        is_int = sgn && (man == 52'd0);
        v = 29'h1000_0000;
      end else begin
        frac_mask = (53'd1 << (6'd52 - u[5:0])) - 53'd1;
        is_int = ((({1'b0, man}) & frac_mask) == 53'd0);
        mag = {1'b1, man} >> (6'd52 - u[5:0]);
        v = sgn ? (29'd0 - mag[28:0]) : mag[28:0];
      end
    end
    built.bytes = '0;
    if (!is_int) begin
      built.bytes = {DBL_MARKER, double_bits};
      built.count = 4'(MaxBytes);
    end else if (v < 29'h80) begin
      built.bytes[71:56] = {INT_MARKER, 1'b0, v[6:0]};
      built.count = 4'd2;
    end else if (v < 29'h4000) begin
      built.bytes[71:48] = {INT_MARKER, 1'b1, v[13:7], 1'b0, v[6:0]};
      built.count = 4'd3;
    end else if (v < 29'h20_0000) begin
      built.bytes[71:40] = {INT_MARKER, 1'b1, v[20:14], 1'b1, v[13:7], 1'b0, v[6:0]};
      built.count = 4'd4;
    end else begin
      built.bytes[71:32] = {INT_MARKER, 1'b1, v[28:22], 1'b1, v[21:15], 1'b1, v[14:8],
                            v[7:0]};
      built.count = 4'd5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= in_valid;
    end
    if (in_valid) begin
      item <= built;
    end
  end
endmodule
`default_nettype wire

// File: hdl/amf3_back.sv
// back end: queue of classified items and byte serializer
`timescale 1ns / 1ps
`default_nettype none
module amf3_back #(
  parameter int Depth = amf3_pkg::QueueDepth
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  amf3_pkg::amf3_item_t      item,
  input  wire logic                 item_valid,
  output logic [$clog2(Depth+1)-1:0] fill,
  output logic [7:0]                out_byte,
  output logic                      last_byte,
  output logic                      out_strobe
);
  import amf3_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  amf3_item_t    mem [Depth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic          active;
  logic [71:0]   shreg;
  logic [3:0]    left;
  logic          pop;

  assign pop = !active || (left == 4'd1);
  wire take = pop && (fill != '0);

  always_ff @(posedge clk) begin
    if (item_valid) begin
      mem[wr_ptr] <= item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
      active <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      if (item_valid) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (item_valid ? 1'b1 : 1'b0) - (take ? 1'b1 : 1'b0);
      out_strobe <= active;
      if (take) begin
        active <= 1'b1;
        shreg <= mem[rd_ptr].bytes;
        left <= mem[rd_ptr].count;
      end else if (active) begin
        if (left == 4'd1) begin
          active <= 1'b0;
        end
        shreg <= shreg << 8;
        left <= left - 4'd1;
      end
    end
    out_byte <= shreg[71:64];
    last_byte <= (left == 4'd1);
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= Depth)
    else $error("queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> (fill < Depth || take))
    else $error("push into full queue");
  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    active |-> left != 4'd0)
    else $error("active with no bytes");
endmodule
`default_nettype wire

// File: hdl/amf3_number_encoder_top.sv
// top level of the amf3 number encoder
// path: front register, queue, shift register, output register; one byte per cycle
// each number is 2 to 9 bytes, sent by the one-byte-per-cycle serializer
// busy rises while the two-entry queue can hold no further item
// synchronous active-high reset empties the queue and the serializer
`timescale 1ns / 1ps
`default_nettype none
module amf3_number_encoder_top #(
  parameter int Depth = amf3_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] double_bits,
  output logic [7:0]       out_byte,
  output logic             last_byte,
  output logic             strobe
);
  import amf3_pkg::*;

  amf3_item_t                 item;
  logic                       item_valid;
  logic [$clog2(Depth+1)-1:0] fill;
  logic                       accept;

  // one item may still be in the front register, so leave a slot for it
  assign busy = (fill + (item_valid ? 1'b1 : 1'b0)) >= Depth;
  assign accept = start && !busy;

  amf3_front u_front (
    .clk(clk), .rst(rst), .in_valid(accept), .double_bits(double_bits),
    .item(item), .item_valid(item_valid)
  );

  amf3_back #(.Depth(Depth)) u_back (
    .clk(clk), .rst(rst), .item(item), .item_valid(item_valid), .fill(fill),
    .out_byte(out_byte), .last_byte(last_byte), .out_strobe(strobe)
  );
endmodule
`default_nettype wire
